>>> sv/json_string_unescaper_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the string unescaper.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_UTF8,
    MODE_ESC,
    MODE_HEX,
    MODE_SUR_BS,
    MODE_SUR_U,
    MODE_HEX2
  } mode_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_UNTERMINATED = 4'd0;
  localparam logic [3:0] ERR_CONTROL      = 4'd1;
  localparam logic [3:0] ERR_BAD_UTF8     = 4'd2;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
  localparam logic [3:0] ERR_HIGH_NO_U    = 4'd4;
  localparam logic [3:0] ERR_NOT_LOW      = 4'd5;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd7;
  localparam logic [3:0] ERR_END_ESCAPE   = 4'd8;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;

  localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SUR_LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam int MaxResults = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
  } result_t;

  typedef struct packed {
    logic [2:0]                count;
    result_t [MaxResults-1:0]  res;
  } batch_t;

  function automatic result_t data_res(input logic [7:0] b);
    result_t r;
    r.out_byte   = b;
    r.kind       = KIND_DATA;
    r.error_code = ERR_UNTERMINATED;
    return r;
  endfunction

  function automatic batch_t single_batch(input logic [1:0] kind, input logic [3:0] code);
    batch_t bt;
    bt                   = '0;
    bt.count             = 3'd1;
    bt.res[0].kind       = kind;
    bt.res[0].error_code = code;
    return bt;
  endfunction

  // bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = {1'b1, c[3:0] + 4'd9};
    end else begin
      d = '0;
    end
    return d;
  endfunction

  function automatic batch_t utf8_encode(input logic [20:0] cp);
    batch_t bt;
    bt = '0;
    if (cp < 21'h80) begin
      bt.count  = 3'd1;
      bt.res[0] = data_res(cp[7:0]);
    end else if (cp < 21'h800) begin
      bt.count  = 3'd2;
      bt.res[0] = data_res({3'b110, cp[10:6]});
      bt.res[1] = data_res({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      bt.count  = 3'd3;
      bt.res[0] = data_res({4'b1110, cp[15:12]});
      bt.res[1] = data_res({2'b10, cp[11:6]});
      bt.res[2] = data_res({2'b10, cp[5:0]});
    end else begin
      bt.count  = 3'd4;
      bt.res[0] = data_res({5'b11110, cp[20:18]});
      bt.res[1] = data_res({2'b10, cp[17:12]});
      bt.res[2] = data_res({2'b10, cp[11:6]});
      bt.res[3] = data_res({2'b10, cp[5:0]});
    end
    return bt;
  endfunction

endpackage

>>> sv/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one text byte or an end-of-text mark per transaction.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

>>> sv/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded result per transaction.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

>>> sv/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step
// Decoder state and the per-byte step: produces the batch of results.
// ----------------------------------------------------------------------------
module jsu_step
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output batch_t     batch
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic [9:0]  high_sur, high_sur_next;
  logic [7:0]  seq_bytes [3];
  logic [1:0]  seq_rem, seq_rem_next;
  logic [1:0]  seq_filled, seq_filled_next;
  logic [7:0]  low_bound, low_bound_next;
  logic [7:0]  high_bound, high_bound_next;
  logic        seq_wr;
  logic [1:0]  seq_wr_idx;

  logic [4:0]  hd;
  logic [15:0] hv;
  logic [1:0]  lead_rem;
  logic [7:0]  lead_lo, lead_hi;

  assign hd = hex_digit(data_byte);
  assign hv = {hex_value[11:0], hd[3:0]};

  always_comb begin
    lead_rem = 2'd0;
    lead_lo  = CONT_LO;
    lead_hi  = CONT_HI;
    if (data_byte inside {[8'hC2:8'hDF]}) begin
      lead_rem = 2'd1;
    end else if (data_byte == 8'hE0) begin
      lead_rem = 2'd2;
      lead_lo  = 8'hA0;
    end else if (data_byte == 8'hED) begin
      lead_rem = 2'd2;
      lead_hi  = 8'h9F;
    end else if (data_byte inside {[8'hE1:8'hEF]}) begin
      lead_rem = 2'd2;
    end else if (data_byte == 8'hF0) begin
      lead_rem = 2'd3;
      lead_lo  = 8'h90;
    end else if (data_byte inside {[8'hF1:8'hF3]}) begin
      lead_rem = 2'd3;
    end else if (data_byte == 8'hF4) begin
      lead_rem = 2'd3;
      lead_hi  = 8'h8F;
    end
  end

  always_comb begin
    logic go_idle;
    go_idle          = 1'b0;
    mode_next        = mode;
    hex_count_next   = hex_count;
    hex_value_next   = hex_value;
    high_sur_next    = high_sur;
    seq_rem_next     = seq_rem;
    seq_filled_next  = seq_filled;
    low_bound_next   = low_bound;
    high_bound_next  = high_bound;
    seq_wr           = 1'b0;
    seq_wr_idx       = seq_filled;
    batch            = '0;

    if (end_of_text) begin
      case (mode)
        MODE_IDLE: ;
        MODE_STR: begin
          batch   = single_batch(KIND_ERROR, ERR_UNTERMINATED);
          go_idle = 1'b1;
        end
        MODE_UTF8: begin
          batch   = single_batch(KIND_ERROR, ERR_BAD_UTF8);
          go_idle = 1'b1;
        end
        MODE_ESC: begin
          batch   = single_batch(KIND_ERROR, ERR_END_ESCAPE);
          go_idle = 1'b1;
        end
        MODE_HEX, MODE_HEX2: begin
          batch   = single_batch(KIND_ERROR, ERR_BAD_HEX);
          go_idle = 1'b1;
        end
        MODE_SUR_BS, MODE_SUR_U: begin
          batch   = single_batch(KIND_ERROR, ERR_HIGH_NO_U);
          go_idle = 1'b1;
        end
        default: go_idle = 1'b1;
      endcase
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (data_byte == CH_QUOTE) mode_next = MODE_STR;
        end
        MODE_STR: begin
          if (data_byte == CH_QUOTE) begin
            batch   = single_batch(KIND_CLOSE, ERR_UNTERMINATED);
            go_idle = 1'b1;
          end else if (data_byte == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else if (data_byte < CH_SPACE) begin
            batch   = single_batch(KIND_ERROR, ERR_CONTROL);
            go_idle = 1'b1;
          end else if (!data_byte[7]) begin
            batch.count  = 3'd1;
            batch.res[0] = data_res(data_byte);
          end else if (lead_rem == 2'd0) begin
            batch   = single_batch(KIND_ERROR, ERR_BAD_UTF8);
            go_idle = 1'b1;
          end else begin
            seq_wr          = 1'b1;
            seq_wr_idx      = 2'd0;
            seq_filled_next = 2'd1;
            seq_rem_next    = lead_rem;
            low_bound_next  = lead_lo;
            high_bound_next = lead_hi;
            mode_next       = MODE_UTF8;
          end
        end
        MODE_UTF8: begin
          if (data_byte < low_bound || data_byte > high_bound) begin
            batch   = single_batch(KIND_ERROR, ERR_BAD_UTF8);
            go_idle = 1'b1;
          end else begin
            low_bound_next  = CONT_LO;
            high_bound_next = CONT_HI;
            seq_rem_next    = seq_rem - 2'd1;
            if (seq_rem != 2'd1) begin
              seq_wr          = (seq_filled != 2'd3);
              seq_filled_next = seq_filled + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (2'(i) < seq_filled) batch.res[i] = data_res(seq_bytes[i]);
              end
              batch.res[seq_filled] = data_res(data_byte);
              batch.count           = {1'b0, seq_filled} + 3'd1;
              seq_filled_next       = 2'd0;
              mode_next             = MODE_STR;
            end
          end
        end
        MODE_ESC: begin
          mode_next   = MODE_STR;
          batch.count = 3'd1;
          case (data_byte)
            8'h22:   batch.res[0] = data_res(8'h22);
            8'h5C:   batch.res[0] = data_res(8'h5C);
            8'h2F:   batch.res[0] = data_res(8'h2F);
            8'h62:   batch.res[0] = data_res(8'h08);
            8'h66:   batch.res[0] = data_res(8'h0C);
            8'h6E:   batch.res[0] = data_res(8'h0A);
            8'h72:   batch.res[0] = data_res(8'h0D);
            8'h74:   batch.res[0] = data_res(8'h09);
            CH_U: begin
              batch          = '0;
              hex_count_next = 2'd0;
              hex_value_next = 16'd0;
              mode_next      = MODE_HEX;
            end
            default: begin
              batch   = single_batch(KIND_ERROR, ERR_BAD_ESCAPE);
              go_idle = 1'b1;
            end
          endcase
        end
        MODE_HEX, MODE_HEX2: begin
          if (!hd[4]) begin
            batch   = single_batch(KIND_ERROR, ERR_BAD_HEX);
            go_idle = 1'b1;
          end else begin
            hex_value_next = hv;
            hex_count_next = hex_count + 2'd1;
            if (hex_count == 2'd3) begin
              if (mode == MODE_HEX) begin
                if (hv inside {[SUR_HIGH_MIN:SUR_HIGH_MAX]}) begin
                  high_sur_next = hv[9:0];
                  mode_next     = MODE_SUR_BS;
                end else if (hv inside {[SUR_LOW_MIN:SUR_LOW_MAX]}) begin
                  batch   = single_batch(KIND_ERROR, ERR_LONE_LOW);
                  go_idle = 1'b1;
                end else begin
                  batch     = utf8_encode({5'd0, hv});
                  mode_next = MODE_STR;
                end
              end else begin
                if (hv inside {[SUR_LOW_MIN:SUR_LOW_MAX]}) begin
                  batch     = utf8_encode(SUPP_BASE + {1'b0, high_sur, hv[9:0]});
                  mode_next = MODE_STR;
                end else begin
                  batch   = single_batch(KIND_ERROR, ERR_NOT_LOW);
                  go_idle = 1'b1;
                end
              end
            end
          end
        end
        MODE_SUR_BS: begin
          if (data_byte == CH_BSLASH) begin
            mode_next = MODE_SUR_U;
          end else begin
            batch   = single_batch(KIND_ERROR, ERR_HIGH_NO_U);
            go_idle = 1'b1;
          end
        end
        MODE_SUR_U: begin
          if (data_byte == CH_U) begin
            hex_count_next = 2'd0;
            hex_value_next = 16'd0;
            mode_next      = MODE_HEX2;
          end else begin
            batch   = single_batch(KIND_ERROR, ERR_HIGH_NO_U);
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
    end

    if (go_idle) begin
      mode_next       = MODE_IDLE;
      hex_count_next  = 2'd0;
      hex_value_next  = 16'd0;
      seq_rem_next    = 2'd0;
      seq_filled_next = 2'd0;
      low_bound_next  = CONT_LO;
      high_bound_next = CONT_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      hex_value  <= 16'd0;
      high_sur   <= 10'd0;
      seq_rem    <= 2'd0;
      seq_filled <= 2'd0;
      low_bound  <= CONT_LO;
      high_bound <= CONT_HI;
    end else if (step) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      hex_value  <= hex_value_next;
      high_sur   <= high_sur_next;
      seq_rem    <= seq_rem_next;
      seq_filled <= seq_filled_next;
      low_bound  <= low_bound_next;
      high_bound <= high_bound_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && seq_wr && seq_wr_idx != 2'd3) begin
      seq_bytes[seq_wr_idx] <= data_byte;
    end
  end

endmodule

>>> sv/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one batch and sends it out one transaction a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module jsu_emit
  import jsu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  batch_t        batch,
  output logic          room,
  jsu_out_if.source     out_ch
);

  result_t [MaxResults-1:0] res;
  logic [2:0]               cnt;
  logic [1:0]               idx;
  logic                     is_last;
  logic                     fire;

  assign is_last = ({1'b0, idx} == cnt - 3'd1);
  assign fire    = out_ch.valid && out_ch.ready;
  assign room    = (cnt == 3'd0) || (fire && is_last);

  assign out_ch.valid      = (cnt != 3'd0);
  assign out_ch.out_byte   = res[idx].out_byte;
  assign out_ch.kind       = res[idx].kind;
  assign out_ch.error_code = res[idx].error_code;
  assign out_ch.last       = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (load && room) begin
      cnt <= batch.count;
      idx <= 2'd0;
    end else if (fire) begin
      if (is_last) begin
        cnt <= 3'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      res <= batch.res;
    end
  end

endmodule

>>> sv/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Path: input register, then the combinational decode step, then the result register.
// Throughput: one byte per cycle while the result register has room; after a byte that
// yields k results the next byte waits in the input register until the last one is taken.
// Reset: synchronous, active high; returns the decoder to idle, outside strings.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_core_assert.svh"

module json_string_unescaper_core
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       room;
  logic       consume;
  batch_t     batch;

  assign consume     = in_valid_q && room;
  assign in_ch.ready = !in_valid_q || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.data_byte;
      in_eot_q  <= in_ch.end_of_text;
    end
  end

  jsu_step u_step (
    .clk         (clk),
    .rst         (rst),
    .step        (consume),
    .data_byte   (in_byte_q),
    .end_of_text (in_eot_q),
    .batch       (batch)
  );

  jsu_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (consume),
    .batch  (batch),
    .room   (room),
    .out_ch (out_ch)
  );

  `JSU_ASSERT_SAME(a_batch_bound, consume, batch.count <= 3'd4, "batch exceeds four results")
  `JSU_ASSERT_NEXT(a_batch_shown, consume && batch.count != 3'd0, out_ch.valid, "batch not presented")
  `JSU_ASSERT_SAME(a_end_is_last, out_ch.valid && out_ch.kind != KIND_DATA, out_ch.last, "close or error not last")

endmodule

>>> tb/tb_json_string_unescaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_core
// Self-checking bench for the JSON string unescaper. A short table of text
// bytes hits the end-of-text and error corners. It is followed by random
// strings: mostly well-formed escapes, surrogate pairs and raw UTF-8 with
// random content, plus injected faults and idle noise. Every result is
// checked field by field against its table row's expectation or an
// in-bench decoder model. The sender idles in bursts, the receiver stalls
// on its own pattern, and once it holds off until the input side backs up.
// ----------------------------------------------------------------------------
module tb_json_string_unescaper_core;
  import jsu_pkg::*;

  localparam int RAND_ITEMS   = 115;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [7:0] CH_SOL  = 8'h2F;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_T = 8'h74;

  localparam logic [7:0] ESC_SET [8] = '{CH_QUOTE, CH_BSLASH, CH_SOL, CH_LC_B,
                                         CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

  // fixed: the row carries its own expectation (some: one result, else none)
  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       fixed;
    logic       some;
    logic [1:0] kind;
    logic [3:0] code;
    logic [7:0] fb;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last;
  } dec_res_t;

  localparam text_item_t DIR_TAB [29] = '{
    '{8'h00,     1'b1, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_U,      1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h30,     1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h30,     1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h30,     1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h30,     1'b0, 1'b1, 1'b1, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b1, KIND_CLOSE, ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h1F,     1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_CONTROL,      8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'hA5,     1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'hE0,     1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h00,     1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_BAD_UTF8,     8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'hED,     1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_BAD_UTF8,     8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h00,     1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_END_ESCAPE,   8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'hFF,     1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_BAD_UTF8,     8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'h7F,     1'b0, 1'b1, 1'b1, KIND_DATA,  ERR_UNTERMINATED, 8'h7F},
    '{8'hC2,     1'b0, 1'b0, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{8'hBF,     1'b0, 1'b0, 1'b0, KIND_DATA,  ERR_UNTERMINATED, 8'h00},
    '{CH_QUOTE,  1'b0, 1'b1, 1'b1, KIND_CLOSE, ERR_UNTERMINATED, 8'h00}
  };

  logic clk;
  logic rst;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescaper_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_item_t text_q [$];
  text_item_t cur_item;
  dec_res_t   step_out [$];
  dec_res_t   decoded_q [$];

  int n_in      = 0;
  int n_results = 0;
  int n_closed  = 0;
  int n_errors  = 0;
  int n_bad     = 0;
  bit hold_req  = 1'b0;
  bit draining  = 1'b0;

  // decoder state
  mode_t      st_mode;
  logic [1:0] hx_cnt;
  logic [15:0] hx_val;
  logic [9:0] hi_sur;
  logic [7:0] seq_b [3];
  logic [1:0] seq_rem;
  logic [1:0] seq_fill;
  logic [7:0] lo_bnd;
  logic [7:0] hi_bnd;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder
  function automatic void put(input logic [7:0] b, input logic [1:0] k,
                              input logic [3:0] c);
    dec_res_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = c;
    r.last       = 1'b0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void back_to_idle();
    st_mode  = MODE_IDLE;
    hx_cnt   = '0;
    hx_val   = '0;
    seq_rem  = '0;
    seq_fill = '0;
    lo_bnd   = CONT_LO;
    hi_bnd   = CONT_HI;
  endfunction

  function automatic void abort(input logic [3:0] c);
    put(8'h00, KIND_ERROR, c);
    back_to_idle();
  endfunction

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0], KIND_DATA, ERR_UNTERMINATED);
    end else if (cp < 21'h800) begin
      put({3'b110, cp[10:6]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[5:0]}, KIND_DATA, ERR_UNTERMINATED);
    end else if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[11:6]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[5:0]}, KIND_DATA, ERR_UNTERMINATED);
    end else begin
      put({5'b11110, cp[20:18]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[17:12]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[11:6]}, KIND_DATA, ERR_UNTERMINATED);
      put({2'b10, cp[5:0]}, KIND_DATA, ERR_UNTERMINATED);
    end
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void open_seq(input logic [7:0] b);
    logic [1:0] rem;
    logic [7:0] lo;
    logic [7:0] hi;
    rem = 2'd0;
    lo  = CONT_LO;
    hi  = CONT_HI;
    if (b >= 8'hC2 && b <= 8'hDF) rem = 2'd1;
    else if (b == 8'hE0) begin rem = 2'd2; lo = 8'hA0; end
    else if (b == 8'hED) begin rem = 2'd2; hi = 8'h9F; end
    else if (b >= 8'hE1 && b <= 8'hEF) rem = 2'd2;
    else if (b == 8'hF0) begin rem = 2'd3; lo = 8'h90; end
    else if (b >= 8'hF1 && b <= 8'hF3) rem = 2'd3;
    else if (b == 8'hF4) begin rem = 2'd3; hi = 8'h8F; end
    if (rem == 2'd0) begin
      abort(ERR_BAD_UTF8);
    end else begin
      seq_b[0] = b;
      seq_fill = 2'd1;
      seq_rem  = rem;
      lo_bnd   = lo;
      hi_bnd   = hi;
      st_mode  = MODE_UTF8;
    end
  endfunction

  function automatic void hex_in(input logic [7:0] b);
    int          d;
    logic [15:0] v;
    d = nibble_of(b);
    if (d < 0) begin
      abort(ERR_BAD_HEX);
      return;
    end
    hx_val = {hx_val[11:0], d[3:0]};
    if (hx_cnt < 2'd3) begin
      hx_cnt++;
      return;
    end
    hx_cnt = '0;
    v = hx_val;
    if (st_mode == MODE_HEX) begin
      if (v >= SUR_HIGH_MIN && v <= SUR_HIGH_MAX) begin
        hi_sur  = 10'(v - SUR_HIGH_MIN);
        st_mode = MODE_SUR_BS;
      end else if (v >= SUR_LOW_MIN && v <= SUR_LOW_MAX) begin
        abort(ERR_LONE_LOW);
      end else begin
        put_cp({5'd0, v});
        st_mode = MODE_STR;
      end
    end else if (v < SUR_LOW_MIN || v > SUR_LOW_MAX) begin
      abort(ERR_NOT_LOW);
    end else begin
      put_cp(SUPP_BASE + {1'b0, hi_sur, 10'd0} + {5'd0, 16'(v - SUR_LOW_MIN)});
      st_mode = MODE_STR;
    end
  endfunction

  function automatic void unescape_step(input logic [7:0] b, input logic eot);
    int i;
    step_out.delete();
    if (eot) begin
      case (st_mode)
        MODE_IDLE:              ;
        MODE_STR:               abort(ERR_UNTERMINATED);
        MODE_UTF8:              abort(ERR_BAD_UTF8);
        MODE_ESC:               abort(ERR_END_ESCAPE);
        MODE_HEX, MODE_HEX2:    abort(ERR_BAD_HEX);
        MODE_SUR_BS, MODE_SUR_U: abort(ERR_HIGH_NO_U);
        default:                back_to_idle();
      endcase
    end else begin
      case (st_mode)
        MODE_IDLE: begin
          if (b == CH_QUOTE) st_mode = MODE_STR;
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            put(8'h00, KIND_CLOSE, ERR_UNTERMINATED);
            back_to_idle();
          end else if (b == CH_BSLASH) begin
            st_mode = MODE_ESC;
          end else if (b < CH_SPACE) begin
            abort(ERR_CONTROL);
          end else if (b < 8'h80) begin
            put(b, KIND_DATA, ERR_UNTERMINATED);
          end else begin
            open_seq(b);
          end
        end
        MODE_UTF8: begin
          if (b < lo_bnd || b > hi_bnd) begin
            abort(ERR_BAD_UTF8);
          end else begin
            lo_bnd  = CONT_LO;
            hi_bnd  = CONT_HI;
            seq_rem = seq_rem - 2'd1;
            if (seq_rem != 2'd0) begin
              if (seq_fill < 2'd3) seq_b[seq_fill] = b;
              seq_fill = seq_fill + 2'd1;
            end else begin
              for (i = 0; i < int'(seq_fill) && i < 3; i++) begin
                put(seq_b[i], KIND_DATA, ERR_UNTERMINATED);
              end
              put(b, KIND_DATA, ERR_UNTERMINATED);
              seq_fill = '0;
              st_mode  = MODE_STR;
            end
          end
        end
        MODE_ESC: begin
          st_mode = MODE_STR;
          case (b)
            CH_QUOTE:  put(8'h22, KIND_DATA, ERR_UNTERMINATED);
            CH_BSLASH: put(8'h5C, KIND_DATA, ERR_UNTERMINATED);
            CH_SOL:    put(8'h2F, KIND_DATA, ERR_UNTERMINATED);
            CH_LC_B:   put(8'h08, KIND_DATA, ERR_UNTERMINATED);
            CH_LC_F:   put(8'h0C, KIND_DATA, ERR_UNTERMINATED);
            CH_LC_N:   put(8'h0A, KIND_DATA, ERR_UNTERMINATED);
            CH_LC_R:   put(8'h0D, KIND_DATA, ERR_UNTERMINATED);
            CH_LC_T:   put(8'h09, KIND_DATA, ERR_UNTERMINATED);
            CH_U: begin
              hx_cnt  = '0;
              hx_val  = '0;
              st_mode = MODE_HEX;
            end
            default:   abort(ERR_BAD_ESCAPE);
          endcase
        end
        MODE_HEX, MODE_HEX2: hex_in(b);
        MODE_SUR_BS: begin
          if (b == CH_BSLASH) st_mode = MODE_SUR_U;
          else abort(ERR_HIGH_NO_U);
        end
        MODE_SUR_U: begin
          if (b == CH_U) begin
            hx_cnt  = '0;
            hx_val  = '0;
            st_mode = MODE_HEX2;
          end else begin
            abort(ERR_HIGH_NO_U);
          end
        end
        default: back_to_idle();
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  // -------------------------------------------------------------- text build
  task automatic add(input logic [7:0] b, input logic eot);
    text_item_t t;
    t     = '0;
    t.b   = b;
    t.eot = eot;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic add_hex4(input logic [15:0] v);
    logic [3:0] d;
    int         i;
    for (i = 3; i >= 0; i--) begin
      d = v[i*4 +: 4];
      if (d < 4'd10) add(8'h30 + d, 1'b0);
      else if ($urandom_range(0, 1) == 0) add(8'h61 + d - 8'd10, 1'b0);
      else add(8'h41 + d - 8'd10, 1'b0);
    end
  endtask

  // raw sequence of len bytes, only the first keep of them sent
  task automatic add_utf8(input int len, input int keep);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    int         k;
    lo = CONT_LO;
    hi = CONT_HI;
    if (len == 2) begin
      lead = 8'($urandom_range(8'hC2, 8'hDF));
    end else if (len == 3) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
    end else begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
    end
    add(lead, 1'b0);
    if (keep > 1) add(8'($urandom_range(hi, lo)), 1'b0);
    for (k = 2; k < keep; k++) add(8'($urandom_range(CONT_HI, CONT_LO)), 1'b0);
  endtask

  task automatic add_piece();
    logic [7:0]  x;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      3, 4, 5: begin
        x = 8'($urandom_range(2, 4));
        add_utf8(int'(x), int'(x));
      end
      6: begin
        add(CH_BSLASH, 1'b0);
        add(ESC_SET[$urandom_range(0, 7)], 1'b0);
      end
      7: begin
        v = 16'($urandom);
        if (v >= SUR_HIGH_MIN && v <= SUR_LOW_MAX) v[15] = 1'b0;
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(v);
      end
      8: begin
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(SUR_HIGH_MIN | 16'($urandom_range(0, 1023)));
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(SUR_LOW_MIN | 16'($urandom_range(0, 1023)));
      end
      default: begin
        x = 8'($urandom_range(8'h7F, 8'h20));
        if (x == CH_QUOTE || x == CH_BSLASH) x = 8'h41;
        add(x, 1'b0);
      end
    endcase
  endtask

  task automatic add_fault();
    logic [7:0]  x;
    logic [15:0] v;
    int          k;
    int          n;
    case ($urandom_range(0, 11))
      0: add(8'($urandom_range(0, 8'h1F)), 1'b0);
      1: begin
        if ($urandom_range(0, 1) == 0) add(8'($urandom_range(8'h80, 8'hC1)), 1'b0);
        else add(8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: begin add(8'hE0, 1'b0); add(8'($urandom_range(8'h80, 8'h9F)), 1'b0); end
          1: begin add(8'hED, 1'b0); add(8'($urandom_range(8'hA0, 8'hBF)), 1'b0); end
          2: begin add(8'hF4, 1'b0); add(8'($urandom_range(8'h90, 8'hBF)), 1'b0); end
          default: begin
            n = $urandom_range(2, 4);
            add_utf8(n, $urandom_range(1, n - 1));
            x = 8'($urandom_range(0, 8'hBF));
            if (x >= 8'h80) x = x + 8'h40;
            add(x, 1'b0);
          end
        endcase
      end
      3: begin
        n = $urandom_range(2, 4);
        add_utf8(n, $urandom_range(1, n - 1));
        add(8'($urandom), 1'b1);
      end
      4: begin
        add(CH_BSLASH, 1'b0);
        x = 8'($urandom);
        while (x inside {CH_QUOTE, CH_BSLASH, CH_SOL, CH_LC_B, CH_LC_F, CH_LC_N,
                         CH_LC_R, CH_LC_T, CH_U}) x = 8'($urandom);
        add(x, 1'b0);
      end
      5: begin
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) add(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          add(8'($urandom), 1'b1);
        end else begin
          x = 8'($urandom);
          while (nibble_of(x) >= 0) x = 8'($urandom);
          add(x, 1'b0);
        end
      end
      6: begin
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(SUR_HIGH_MIN | 16'($urandom_range(0, 1023)));
        case ($urandom_range(0, 3))
          0: begin
            x = 8'($urandom);
            if (x == CH_BSLASH) x = 8'h41;
            add(x, 1'b0);
          end
          1: add(8'($urandom), 1'b1);
          2: begin
            add(CH_BSLASH, 1'b0);
            x = 8'($urandom);
            if (x == CH_U) x = 8'h41;
            add(x, 1'b0);
          end
          default: begin
            add(CH_BSLASH, 1'b0);
            add(8'($urandom), 1'b1);
          end
        endcase
      end
      7: begin
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(SUR_HIGH_MIN | 16'($urandom_range(0, 1023)));
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        v = 16'($urandom);
        if (v >= SUR_LOW_MIN && v <= SUR_LOW_MAX) v[15] = 1'b0;
        add_hex4(v);
      end
      8: begin
        add(CH_BSLASH, 1'b0);
        add(CH_U, 1'b0);
        add_hex4(SUR_LOW_MIN | 16'($urandom_range(0, 1023)));
      end
      9: begin
        add(CH_BSLASH, 1'b0);
        add(8'($urandom), 1'b1);
      end
      10: begin
        add(8'($urandom), 1'b0);
        add(8'($urandom), 1'b1);
      end
      default: add(8'($urandom), 1'b1);
    endcase
  endtask

  task automatic add_string();
    int np;
    int fault_at;
    int p;
    add(CH_QUOTE, 1'b0);
    np       = $urandom_range(0, 6);
    fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, np) : -1;
    for (p = 0; p < np; p++) begin
      if (p == fault_at) begin
        add_fault();
        return;
      end
      add_piece();
    end
    if (fault_at == np) add_fault();
    else if ($urandom_range(0, 7) == 0) add(8'($urandom), 1'b1);
    else add(CH_QUOTE, 1'b0);
  endtask

  task automatic add_noise();
    logic [7:0] x;
    int         n;
    int         k;
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) begin
      x = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        add(x, 1'b1);
      end else begin
        if (x == CH_QUOTE) x = 8'h27;
        add(x, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------- sender
  initial begin : sender
    int burst_left;
    int gap;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    cur_item          = '0;
    hi_sur            = '0;
    seq_b             = '{default: 8'h00};
    back_to_idle();
    foreach (DIR_TAB[i]) text_q.insert(text_q.size(), DIR_TAB[i]);
    while (text_q.size() < $size(DIR_TAB) + RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) add_noise();
      add_string();
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = 0;
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      cur_item = text_q[i];
      in_ch.valid       <= 1'b1;
      in_ch.data_byte   <= text_q[i].b;
      in_ch.end_of_text <= text_q[i].eot;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    draining = 1'b1;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d text transactions and %0d results (%0d closed strings, %0d errors)",
             n_in, n_results, n_closed, n_errors);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // -------------------------------------------------------------- receiver
  initial begin : receiver
    int  hold_cnt;
    int  phase;
    int  phase_left;
    bit  hold_done;
    hold_cnt     = 0;
    phase        = 0;
    phase_left   = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt != 0) begin
        out_ch.ready <= 1'b0;
        hold_cnt--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (draining) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase      = $urandom_range(0, 2);
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        case (phase)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // -------------------------------------------------------- predict / check
  always @(posedge clk) begin : scoreboard
    dec_res_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        unescape_step(in_ch.data_byte, in_ch.end_of_text);
        if (cur_item.fixed) begin
          if (cur_item.some) begin
            want.out_byte   = cur_item.fb;
            want.kind       = cur_item.kind;
            want.error_code = cur_item.code;
            want.last       = 1'b1;
            decoded_q.insert(decoded_q.size(), want);
          end
        end else begin
          foreach (step_out[k]) decoded_q.insert(decoded_q.size(), step_out[k]);
        end
        n_in++;
        if (n_in == $size(DIR_TAB) + 60) hold_req = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.kind == KIND_CLOSE) n_closed++;
        if (out_ch.kind == KIND_ERROR) n_errors++;
        if (decoded_q.size() == 0) begin
          $error("result with none pending: out_byte %h kind %0d error_code %0d",
                 out_ch.out_byte, out_ch.kind, out_ch.error_code);
          n_bad++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
            n_bad++;
          end
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            n_bad++;
          end
          if (out_ch.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_ch.error_code);
            n_bad++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            n_bad++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- watchdog
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cyc, decoded_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_in_if.sv
sv/jsu_out_if.sv
sv/jsu_step.sv
sv/jsu_emit.sv
sv/json_string_unescaper_core.sv
tb/tb_json_string_unescaper_core.sv
